// ===== src/gbn_pkg.sv =====
`default_nettype none
package gbn_pkg;

    // Packet numbers, counters and configuration data are 16 bits wide; the window size uses 6 of them.
    localparam int SEQ_W = 16;
    typedef logic [SEQ_W-1:0] t_seq;

    // The end-of-transfer word carries all ones as its packet number.
    localparam t_seq END_MARK = '1;

    // Item kinds.
    localparam int OP_W = 2;
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_SEND = 2'd0;
    localparam t_op OP_ACK  = 2'd1;
    localparam t_op OP_TICK = 2'd2;

    // Configuration register map.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WSIZE_W    = 6;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WINDOW_SIZE   = 2'd0;
    localparam t_cfg_idx CFG_PACKET_COUNT  = 2'd1;
    localparam t_cfg_idx CFG_TIMEOUT_TICKS = 2'd2;

    localparam logic [WSIZE_W-1:0] RST_WINDOW_SIZE   = 6'd4;
    localparam t_seq               RST_PACKET_COUNT  = 16'd16;
    localparam t_seq               RST_TIMEOUT_TICKS = 16'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLIDE,
        ST_RESEND
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;         // capture the accepted input word
        logic send_emit;     // load the send-slot result into the output register
        logic mark;          // set the acknowledge mark of the latched ack
        logic slide_step;    // clear the base mark and advance the base by one
        logic wait_clear;    // clear the full-window tick counter
        logic wait_inc;      // saturating increment of the tick counter
        logic resend_start;  // rewind the send pointer to the base, latch the stop point
        logic resend_emit;   // load one retransmission into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic send_has;      // a send slot produces a word
        logic ack_ok;        // latched ack lies inside the window
        logic full;          // window is full
        logic timeout_hit;   // this tick reaches the timeout
        logic slide_more;    // base packet is marked and below the packet count
        logic at_stop;       // send pointer sits at the last packet to resend
        logic out_free;      // output register can take a word this cycle
    } t_stat;

endpackage
`default_nettype wire

// ===== src/gbn_in_if.sv =====
`default_nettype none
interface gbn_in_if import gbn_pkg::*; ();
    logic valid;
    logic ready;
    t_op  op;
    t_seq ack_number;

    modport source (output valid, output op, output ack_number, input ready);
    modport sink   (input valid, input op, input ack_number, output ready);
endinterface
`default_nettype wire

// ===== src/gbn_out_if.sv =====
`default_nettype none
interface gbn_out_if import gbn_pkg::*; ();
    logic valid;
    logic ready;
    t_seq packet_number;
    logic end_of_transfer;
    logic is_resend;
    logic last;

    modport source (output valid, output packet_number, output end_of_transfer,
                    output is_resend, output last, input ready);
    modport sink   (input valid, input packet_number, input end_of_transfer,
                    input is_resend, input last, output ready);
endinterface
`default_nettype wire

// ===== src/gbn_cfg.sv =====
`default_nettype none
module gbn_cfg import gbn_pkg::*; #(
    parameter int WINDOW_MAX = 32,
    localparam int WW = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic      [WW-1:0]         o_win,
    output t_seq                       o_pcount,
    output t_seq                       o_limit
);

    localparam int CW = (WSIZE_W > WW) ? WSIZE_W : WW;

    logic [WSIZE_W-1:0] r_window_size;
    t_seq               r_packet_count;
    t_seq               r_timeout_ticks;
    logic [CW-1:0]      ws_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size   <= RST_WINDOW_SIZE;
            r_packet_count  <= RST_PACKET_COUNT;
            r_timeout_ticks <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[WSIZE_W-1:0];
                CFG_PACKET_COUNT:  r_packet_count  <= i_cfg_data[SEQ_W-1:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[SEQ_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero window acts as one; a window above the mark storage acts as its depth.
    assign ws_ext = CW'(r_window_size);

    always_comb begin
        if (r_window_size == '0) begin
            o_win = WW'(1);
        end else if (ws_ext > CW'(WINDOW_MAX)) begin
            o_win = WW'(WINDOW_MAX);
        end else begin
            o_win = WW'(ws_ext);
        end
    end

    // The all-ones number is the end marker, so the packet count never exceeds it;
    // with 16-bit numbers the register can hold nothing larger.
    assign o_pcount = r_packet_count;
    assign o_limit  = (r_timeout_ticks == '0) ? t_seq'(1) : r_timeout_ticks;

endmodule
`default_nettype wire

// ===== src/gbn_ctrl.sv =====
`default_nettype none
module gbn_ctrl import gbn_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (i_stat.op)
                    OP_SEND: begin
                        if (!i_stat.send_has || i_stat.out_free) n_state = ST_IDLE;
                    end
                    OP_ACK: begin
                        n_state = i_stat.ack_ok ? ST_SLIDE : ST_IDLE;
                    end
                    OP_TICK: begin
                        n_state = (i_stat.full && i_stat.timeout_hit) ? ST_RESEND : ST_IDLE;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_SLIDE: begin
                if (!i_stat.slide_more) n_state = ST_IDLE;
            end
            ST_RESEND: begin
                if (i_stat.out_free && i_stat.at_stop) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: begin
                case (i_stat.op)
                    OP_SEND: begin
                        o_cmd.send_emit = i_stat.send_has && i_stat.out_free;
                    end
                    OP_ACK: begin
                        o_cmd.mark = i_stat.ack_ok;
                    end
                    OP_TICK: begin
                        if (!i_stat.full) begin
                            o_cmd.wait_clear = 1'b1;
                        end else if (i_stat.timeout_hit) begin
                            o_cmd.resend_start = 1'b1;
                        end else begin
                            o_cmd.wait_inc = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SLIDE: begin
                o_cmd.slide_step = i_stat.slide_more;
            end
            ST_RESEND: begin
                o_cmd.resend_emit = i_stat.out_free;
            end
            default: ;
        endcase
    end

    // A word is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.send_emit || o_cmd.resend_emit) |-> i_stat.out_free)
        else $error("word loaded into a full output register");

    // The final retransmission returns the controller to idle.
    a_resend_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.resend_emit && i_stat.at_stop) |=> (r_state == ST_IDLE))
        else $error("resend burst did not end at its stop point");

    // State-changing datapath commands never overlap.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.latch, o_cmd.send_emit, o_cmd.mark, o_cmd.slide_step,
                  o_cmd.wait_clear, o_cmd.wait_inc, o_cmd.resend_start,
                  o_cmd.resend_emit}))
        else $error("overlapping datapath commands");

endmodule
`default_nettype wire

// ===== src/gbn_dp.sv =====
`default_nettype none
module gbn_dp import gbn_pkg::*; #(
    parameter int WINDOW_MAX = 32,
    localparam int WW = $clog2(WINDOW_MAX + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    output t_stat              o_stat,
    input  wire logic [WW-1:0] i_win,
    input  wire t_seq          i_pcount,
    input  wire t_seq          i_limit,
    input  wire t_op           i_op,
    input  wire t_seq          i_ack_number,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output t_seq               o_packet_number,
    output logic               o_end_of_transfer,
    output logic               o_is_resend,
    output logic               o_last
);

    localparam int IW = $clog2(WINDOW_MAX);
    localparam int TW = SEQ_W + 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(WINDOW_MAX - 1);

    t_op                   r_op;
    t_seq                  r_ack;
    t_seq                  r_base;
    t_seq                  r_next;
    t_seq                  r_wait;
    t_seq                  r_stop;
    logic                  r_finished;
    logic [IW-1:0]         r_base_idx;
    logic [WINDOW_MAX-1:0] r_marks;

    logic                  r_out_valid;
    t_seq                  r_out_num;
    logic                  r_out_end;
    logic                  r_out_rs;
    logic                  r_out_last;

    logic [TW-1:0] top;
    logic [TW-1:0] pc_m1;
    logic [TW-1:0] stop;
    t_seq          wait_inc;
    t_seq          ack_off;
    logic [IW:0]   idx_sum;
    logic [IW-1:0] ack_idx;
    logic [IW-1:0] base_idx_inc;
    logic          out_free;

    // Window top is base + size - 1, one bit wider than a packet number.
    assign top   = TW'(r_base) + TW'(i_win) - TW'(1);
    assign pc_m1 = TW'(i_pcount) - TW'(1);
    assign stop  = (top < pc_m1) ? top : pc_m1;

    assign wait_inc = (r_wait != '1) ? r_wait + t_seq'(1) : r_wait;

    // Mark slot of the ack: the base slot plus the offset into the window, wrapped once.
    assign ack_off = r_ack - r_base;
    assign idx_sum = (IW + 1)'(r_base_idx) + (IW + 1)'(ack_off[IW-1:0]);
    assign ack_idx = (idx_sum >= (IW + 1)'(WINDOW_MAX)) ?
                     IW'(idx_sum - (IW + 1)'(WINDOW_MAX)) : IW'(idx_sum);

    assign base_idx_inc = (r_base_idx == IDX_LAST) ? '0 : r_base_idx + IW'(1);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.op          = r_op;
        o_stat.send_has    = !r_finished &&
                             ((r_next >= i_pcount) || (TW'(r_next) <= top));
        o_stat.ack_ok      = (r_ack >= r_base) && (TW'(r_ack) <= top) && (r_ack < i_pcount);
        o_stat.full        = (r_next < i_pcount) && (TW'(r_next) > top);
        o_stat.timeout_hit = wait_inc >= i_limit;
        o_stat.slide_more  = (r_base < i_pcount) && r_marks[r_base_idx];
        o_stat.at_stop     = (r_next == r_stop);
        o_stat.out_free    = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_op;
            r_ack <= i_ack_number;
        end
        if (i_cmd.resend_start) begin
            r_stop <= stop[SEQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_next     <= '0;
            r_wait     <= '0;
            r_finished <= 1'b0;
            r_base_idx <= '0;
            r_marks    <= '0;
        end else begin
            if (i_cmd.send_emit) begin
                if (r_next < i_pcount) begin
                    r_next <= r_next + t_seq'(1);
                end else begin
                    r_finished <= 1'b1;
                end
            end
            if (i_cmd.mark) begin
                r_marks[ack_idx] <= 1'b1;
            end
            if (i_cmd.slide_step) begin
                r_marks[r_base_idx] <= 1'b0;
                r_base              <= r_base + t_seq'(1);
                r_base_idx          <= base_idx_inc;
                r_wait              <= '0;
            end
            if (i_cmd.wait_clear) begin
                r_wait <= '0;
            end
            if (i_cmd.wait_inc) begin
                r_wait <= wait_inc;
            end
            if (i_cmd.resend_start) begin
                r_next <= r_base;
                r_wait <= '0;
            end
            if (i_cmd.resend_emit) begin
                r_next <= r_next + t_seq'(1);
            end
        end
    end

    // Output register: loads a word when free, otherwise holds it until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.send_emit || i_cmd.resend_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send_emit) begin
            r_out_num  <= (r_next < i_pcount) ? r_next : END_MARK;
            r_out_end  <= !(r_next < i_pcount);
            r_out_rs   <= 1'b0;
            r_out_last <= 1'b1;
        end else if (i_cmd.resend_emit) begin
            r_out_num  <= r_next;
            r_out_end  <= 1'b0;
            r_out_rs   <= 1'b1;
            r_out_last <= (r_next == r_stop);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_packet_number   = r_out_num;
    assign o_end_of_transfer = r_out_end;
    assign o_is_resend       = r_out_rs;
    assign o_last            = r_out_last;

    // The base slot tracks the base modulo the mark depth and never leaves the array.
    a_base_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IW + 1)'(r_base_idx) < (IW + 1)'(WINDOW_MAX))
        else $error("base slot outside the mark array");

    // A timeout burst always starts with the tick counter cleared.
    a_resend_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.resend_start |=> (r_wait == '0))
        else $error("tick counter not cleared at resend start");

endmodule
`default_nettype wire

// ===== src/go_back_n_sender_window.sv =====
`default_nettype none
// Channel   Dir  Fields                                           Meaning
// i_item    in   op, ack_number                                   send slot, ack or tick
// o_result  out  packet_number, end_of_transfer, is_resend, last  packet to transmit
// i_cfg_*   in   we, idx, data                                    window, count, timeout
//
// An input word is taken in one cycle and worked in the next. A send slot, a tick without
// timeout and an ack outside the window end there, a send slot once the output can take its word.
// An ack inside the window then steps the window base past each marked packet; a timeout
// then retransmits each packet from the base to the stop point whenever the output register
// can take a word.
// Reset is synchronous and active low; it clears the acknowledge marks.
// A stalled output holds its word while a following send slot waits in the datapath.
module go_back_n_sender_window import gbn_pkg::*; #(
    parameter int WINDOW_MAX = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_idx              i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    gbn_in_if.sink                     i_item,
    gbn_out_if.source                  o_result
);

    localparam int WW = $clog2(WINDOW_MAX + 1);

    // Effective configuration: window clamped to the mark depth, timeout at least one.
    logic [WW-1:0] win;
    t_seq          pcount;
    t_seq          limit;

    // Controller and datapath talk only through these two bundles.
    t_cmd  cmd;
    t_stat stat;

    gbn_cfg #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_win      (win),
        .o_pcount   (pcount),
        .o_limit    (limit)
    );

    // The controller accepts a new word only when it is idle, and sequences the window slide
    // and the resend burst one packet per cycle, the burst only while the output is free.
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the window pointers, the marks and the output register.
    gbn_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_win             (win),
        .i_pcount          (pcount),
        .i_limit           (limit),
        .i_op              (i_item.op),
        .i_ack_number      (i_item.ack_number),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_packet_number   (o_result.packet_number),
        .o_end_of_transfer (o_result.end_of_transfer),
        .o_is_resend       (o_result.is_resend),
        .o_last            (o_result.last)
    );

endmodule
`default_nettype wire
